@@ hdl/bse_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and tap tables for the Bezier surface evaluator.
package bse_pkg;

	// Field widths
	localparam int COORD_W   = 32;
	localparam int PARAM_W   = 16;
	localparam int KIND_W    = 3;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int LANES     = 3;

	// Default net limits
	localparam int DEF_MAX_U_POINTS = 16;
	localparam int DEF_MAX_V_POINTS = 16;

	// Internal value widths: difference nets stay exact in VAL_W bits
	localparam int VAL_W   = 46;
	localparam int SUM_W   = 35;
	localparam int SCALE_W = 10;

	localparam logic [PARAM_W-1:0] Q_ONE = 16'd32768;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_U_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_V_COUNT = 2'd1;

	// Request types
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// Derivative kinds
	localparam logic [KIND_W-1:0] KIND_POINT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DU    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DV    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DUU   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DUV   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DVV   = 3'd5;

	// Tap weights
	localparam logic [1:0] W_POS  = 2'd0;
	localparam logic [1:0] W_NEG  = 2'd1;
	localparam logic [1:0] W_NEG2 = 2'd2;

	typedef struct packed {
		logic                      req_type;
		logic [IDX_W-1:0]          u_index;
		logic [IDX_W-1:0]          v_index;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [PARAM_W-1:0]        param_u;
		logic [PARAM_W-1:0]        param_v;
		logic [KIND_W-1:0]         derivative_kind;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] result_x;
		logic signed [COORD_W-1:0] result_y;
		logic signed [COORD_W-1:0] result_z;
		logic                      saturated;
	} out_t;

	typedef logic [LANES-1:0][COORD_W-1:0] net_word_t;
	typedef logic [LANES-1:0][VAL_W-1:0]   lanes_t;

	typedef struct packed {
		logic [1:0] du;
		logic [1:0] dv;
		logic [1:0] w;
	} tap_t;

	// Number of net taps that form one entry of the difference net
	function automatic logic [2:0] tap_count(input logic [KIND_W-1:0] kind);
		logic [2:0] n;
		case (kind)
			KIND_DU, KIND_DV:   n = 3'd2;
			KIND_DUU, KIND_DVV: n = 3'd3;
			KIND_DUV:           n = 3'd4;
			default:            n = 3'd1;
		endcase
		return n;
	endfunction

	// Offset and weight of tap j
	function automatic tap_t tap_of(input logic [KIND_W-1:0] kind, input logic [1:0] j);
		tap_t t;
		t = '{du: 2'd0, dv: 2'd0, w: W_POS};
		case (kind)
			KIND_DU: begin
				if (j == 2'd0) t = '{du: 2'd0, dv: 2'd0, w: W_NEG};
				else           t = '{du: 2'd1, dv: 2'd0, w: W_POS};
			end
			KIND_DV: begin
				if (j == 2'd0) t = '{du: 2'd0, dv: 2'd0, w: W_NEG};
				else           t = '{du: 2'd0, dv: 2'd1, w: W_POS};
			end
			KIND_DUU: begin
				case (j)
					2'd0:    t = '{du: 2'd0, dv: 2'd0, w: W_POS};
					2'd1:    t = '{du: 2'd1, dv: 2'd0, w: W_NEG2};
					default: t = '{du: 2'd2, dv: 2'd0, w: W_POS};
				endcase
			end
			KIND_DVV: begin
				case (j)
					2'd0:    t = '{du: 2'd0, dv: 2'd0, w: W_POS};
					2'd1:    t = '{du: 2'd0, dv: 2'd1, w: W_NEG2};
					default: t = '{du: 2'd0, dv: 2'd2, w: W_POS};
				endcase
			end
			KIND_DUV: begin
				case (j)
					2'd0:    t = '{du: 2'd0, dv: 2'd0, w: W_POS};
					2'd1:    t = '{du: 2'd1, dv: 2'd0, w: W_NEG};
					2'd2:    t = '{du: 2'd0, dv: 2'd1, w: W_NEG};
					default: t = '{du: 2'd1, dv: 2'd1, w: W_POS};
				endcase
			end
			default: t = '{du: 2'd0, dv: 2'd0, w: W_POS};
		endcase
		return t;
	endfunction

endpackage

@@ hdl/bse_net_store.sv @@
`timescale 1ns / 1ps
// Control net memory: one write port, one registered read port.
module bse_net_store #(
	parameter int MAX_U_POINTS = bse_pkg::DEF_MAX_U_POINTS,
	parameter int MAX_V_POINTS = bse_pkg::DEF_MAX_V_POINTS,
	localparam int DEPTH = MAX_U_POINTS * MAX_V_POINTS,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  bse_pkg::net_word_t wdata,
	input  logic [AW-1:0]      raddr,
	output bse_pkg::net_word_t rdata
);

	bse_pkg::net_word_t mem [DEPTH];

	// write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bse_work_store.sv @@
`timescale 1ns / 1ps
// Scratch memory for the row and column point sets, three lanes wide.
module bse_work_store #(
	parameter int MAX_U_POINTS = bse_pkg::DEF_MAX_U_POINTS,
	parameter int MAX_V_POINTS = bse_pkg::DEF_MAX_V_POINTS,
	localparam int DEPTH = MAX_U_POINTS + MAX_V_POINTS,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bse_pkg::lanes_t wdata,
	input  logic [AW-1:0]   raddr,
	output bse_pkg::lanes_t rdata
);

	bse_pkg::lanes_t mem [DEPTH];

	// write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/bse_lerp_pipe.sv @@
`timescale 1ns / 1ps
// Two-stage lerp datapath: r = a + floor(((b - a) * t + 0.5) / 1.0), Q1.15 t.
module bse_lerp_pipe #(
	parameter int TAG_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  bse_pkg::lanes_t             in_a,
	input  bse_pkg::lanes_t             in_b,
	input  logic [bse_pkg::PARAM_W-1:0] t,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_vld,
	output bse_pkg::lanes_t             out_val,
	output logic [TAG_W-1:0]            out_tag,
	output logic                        busy
);

	localparam int DW = bse_pkg::VAL_W + 1;
	localparam int PW = DW + bse_pkg::PARAM_W + 1;
	localparam int LANES = bse_pkg::LANES;

	logic                         vld_s1, vld_s2;
	bse_pkg::lanes_t              a_s1, a_s2;
	logic [LANES-1:0][DW-1:0]     d_s1;
	logic [LANES-1:0][PW-1:0]     p_s2;
	logic [TAG_W-1:0]             tag_s1, tag_s2;
	logic signed [bse_pkg::PARAM_W:0] t_sx;

	assign t_sx = $signed({1'b0, t});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: difference
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			d_s1[l] <= DW'($signed(in_b[l])) - DW'($signed(in_a[l]));
		end
		a_s1   <= in_a;
		tag_s1 <= in_tag;
	end

	// stage 2: scale by t
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			p_s2[l] <= PW'($signed(d_s1[l])) * PW'(t_sx);
		end
		a_s2   <= a_s1;
		tag_s2 <= tag_s1;
	end

	// round half up, floor shift, add base
	always_comb begin
		logic signed [PW-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = ($signed(p_s2[l]) + PW'(16384)) >>> 15;
			out_val[l] = a_s2[l] + q[bse_pkg::VAL_W-1:0];
		end
	end

	assign out_vld = vld_s2;
	assign out_tag = tag_s2;
	assign busy    = vld_s1 | vld_s2;

endmodule

@@ hdl/bezier_surface_evaluator.sv @@
`timescale 1ns / 1ps
// Top level: Bezier surface evaluator with net memory, scratch memory and lerp unit.
//
//  channel   dir  handshake                 payload
//  in        in   in_valid / in_stall       in_data  (bse_pkg::in_t)
//  out       out  out_valid / out_stall     out_data (bse_pkg::out_t)
//  cfg       in   cfg_we                    cfg_index, cfg_data
//
// An evaluate beat is bounded by the single scratch memory read port, which feeds the lerp unit
// one point per cycle.
// Reset clears control state only; the memories are not cleared.
// in_stall is high while an evaluation runs; a finished result waits in the output register.
module bezier_surface_evaluator #(
	parameter int MAX_U_POINTS = bse_pkg::DEF_MAX_U_POINTS,
	parameter int MAX_V_POINTS = bse_pkg::DEF_MAX_V_POINTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bse_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bse_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [bse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bse_pkg::CNT_W-1:0]     cfg_data
);

	localparam int NA_W  = $clog2(MAX_U_POINTS * MAX_V_POINTS);
	localparam int WA_W  = $clog2(MAX_U_POINTS + MAX_V_POINTS);
	localparam int CNT_W = bse_pkg::CNT_W;
	localparam int VAL_W = bse_pkg::VAL_W;
	localparam int SUM_W = bse_pkg::SUM_W;
	localparam int SC_W  = bse_pkg::SCALE_W;
	localparam int LANES = bse_pkg::LANES;
	localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'(64'sd2147483647);
	localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(-64'sd2147483648);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_GATHER = 3'd1;
	localparam logic [2:0] S_GDRAIN = 3'd2;
	localparam logic [2:0] S_LERP   = 3'd3;
	localparam logic [2:0] S_LDRAIN = 3'd4;
	localparam logic [2:0] S_COPY   = 3'd5;
	localparam logic [2:0] S_COPY2  = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0]                     state_q;
	logic [CNT_W-1:0]               u_cnt_q, v_cnt_q;
	logic [bse_pkg::KIND_W-1:0]     kind_q;
	logic [bse_pkg::PARAM_W-1:0]    tu_q, tv_q;
	logic [CNT_W-1:0]               nu_e_q, nv_e_q;
	logic [SC_W-1:0]                scale_q;
	logic [2:0]                     ntap_q;
	logic [CNT_W-1:0]               row_q, pos_q, level_q;
	logic [1:0]                     tap_q;
	logic                           col_q;
	bse_pkg::out_t                  res_q, out_q;
	logic                           out_valid_q;

	// gather pipeline
	logic                           g1_vld_q, g1_first_q, g1_last_q;
	logic [1:0]                     g1_w_q;
	logic [CNT_W-1:0]               g1_u_q;
	logic [LANES-1:0][SUM_W-1:0]    acc_q, acc_n;
	logic                           g2_vld_s2;
	logic [LANES-1:0][SUM_W-1:0]    g2_sum_s2;
	logic [CNT_W-1:0]               g2_u_s2;
	logic                           g3_vld_s3;
	bse_pkg::lanes_t                g3_val_s3;
	logic [CNT_W-1:0]               g3_u_s3;

	// lerp feed
	logic                           c1_vld_q;
	logic [CNT_W-1:0]               c1_pos_q;
	bse_pkg::lanes_t                a_q;

	// memories
	logic                           net_we;
	logic [NA_W-1:0]                net_waddr, net_raddr;
	bse_pkg::net_word_t             net_wdata, net_rdata;
	logic                           wk_we;
	logic [WA_W-1:0]                wk_waddr, wk_raddr;
	bse_pkg::lanes_t                wk_wdata, wk_rdata;

	// lerp unit
	logic                           lp_in_vld, lp_out_vld, lp_busy;
	logic [WA_W-1:0]                lp_in_tag, lp_out_tag;
	bse_pkg::lanes_t                lp_out_val;

	// decode of an accepted evaluate beat
	logic                           in_acc;
	logic [bse_pkg::KIND_W-1:0]     kind_n;
	logic [1:0]                     du_ord, dv_ord;
	logic [CNT_W-1:0]               su, sv;
	logic [SC_W-1:0]                scale_n;
	logic                           zero_n;
	bse_pkg::tap_t                  tp;
	logic                           last_tap;
	logic [WA_W-1:0]                base;
	logic [CNT_W-1:0]               start_n;
	bse_pkg::out_t                  clamp_res;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		kind_n = (in_data.derivative_kind > bse_pkg::KIND_DVV) ? bse_pkg::KIND_POINT
			: in_data.derivative_kind;
		su = u_cnt_q - CNT_W'(1);
		sv = v_cnt_q - CNT_W'(1);
		case (kind_n)
			bse_pkg::KIND_DU: begin
				du_ord = 2'd1; dv_ord = 2'd0; scale_n = SC_W'(su);
			end
			bse_pkg::KIND_DV: begin
				du_ord = 2'd0; dv_ord = 2'd1; scale_n = SC_W'(sv);
			end
			bse_pkg::KIND_DUU: begin
				du_ord = 2'd2; dv_ord = 2'd0;
				scale_n = SC_W'(su) * SC_W'(su - CNT_W'(1));
			end
			bse_pkg::KIND_DUV: begin
				du_ord = 2'd1; dv_ord = 2'd1; scale_n = SC_W'(su) * SC_W'(sv);
			end
			bse_pkg::KIND_DVV: begin
				du_ord = 2'd0; dv_ord = 2'd2;
				scale_n = SC_W'(sv) * SC_W'(sv - CNT_W'(1));
			end
			default: begin
				du_ord = 2'd0; dv_ord = 2'd0; scale_n = SC_W'(1);
			end
		endcase
		zero_n = ((kind_n == bse_pkg::KIND_DUU) && (u_cnt_q == CNT_W'(2)))
			|| ((kind_n == bse_pkg::KIND_DVV) && (v_cnt_q == CNT_W'(2)));
	end

	// configuration registers, clamped into 2..MAX
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_cnt_q <= CNT_W'(4);
			v_cnt_q <= CNT_W'(4);
		end else if (cfg_we) begin
			if (cfg_index == bse_pkg::REG_U_COUNT) begin
				if (cfg_data < CNT_W'(2))                 u_cnt_q <= CNT_W'(2);
				else if (int'(cfg_data) > MAX_U_POINTS)   u_cnt_q <= CNT_W'(MAX_U_POINTS);
				else                                      u_cnt_q <= cfg_data;
			end else if (cfg_index == bse_pkg::REG_V_COUNT) begin
				if (cfg_data < CNT_W'(2))                 v_cnt_q <= CNT_W'(2);
				else if (int'(cfg_data) > MAX_V_POINTS)   v_cnt_q <= CNT_W'(MAX_V_POINTS);
				else                                      v_cnt_q <= cfg_data;
			end
		end
	end

	// net loads
	assign net_we = in_acc && (in_data.req_type == bse_pkg::REQ_LOAD)
		&& (int'(in_data.u_index) < MAX_U_POINTS) && (int'(in_data.v_index) < MAX_V_POINTS);
	assign net_waddr = NA_W'(int'(in_data.v_index) * MAX_U_POINTS + int'(in_data.u_index));
	assign net_wdata = {in_data.coord_z, in_data.coord_y, in_data.coord_x};

	// gather address
	assign tp        = bse_pkg::tap_of(kind_q, tap_q);
	assign last_tap  = ({1'b0, tap_q} == (ntap_q - 3'd1));
	assign net_raddr = NA_W'((int'(row_q) + int'(tp.dv)) * MAX_U_POINTS
		+ int'(pos_q) + int'(tp.du));

	// tap accumulate
	always_comb begin
		logic signed [SUM_W-1:0] p;
		logic signed [SUM_W-1:0] term;
		for (int l = 0; l < LANES; l++) begin
			p = SUM_W'($signed(net_rdata[l]));
			case (g1_w_q)
				bse_pkg::W_POS:  term = p;
				bse_pkg::W_NEG:  term = -p;
				bse_pkg::W_NEG2: term = -(p <<< 1);
				default:         term = '0;
			endcase
			acc_n[l] = (g1_first_q ? SUM_W'(0) : acc_q[l]) + term;
		end
	end

	// gather pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_vld_q  <= 1'b0;
			g2_vld_s2 <= 1'b0;
			g3_vld_s3 <= 1'b0;
			c1_vld_q  <= 1'b0;
		end else begin
			g1_vld_q  <= (state_q == S_GATHER);
			g2_vld_s2 <= g1_vld_q && g1_last_q;
			g3_vld_s3 <= g2_vld_s2;
			c1_vld_q  <= (state_q == S_LERP);
		end
	end

	// gather pipeline payload
	always_ff @(posedge clk) begin
		g1_w_q     <= tp.w;
		g1_first_q <= (tap_q == 2'd0);
		g1_last_q  <= last_tap;
		g1_u_q     <= pos_q;
		if (g1_vld_q) begin
			acc_q <= acc_n;
		end
		g2_sum_s2 <= acc_n;
		g2_u_s2   <= g1_u_q;
		for (int l = 0; l < LANES; l++) begin
			g3_val_s3[l] <= VAL_W'($signed(g2_sum_s2[l])) * VAL_W'($signed({1'b0, scale_q}));
		end
		g3_u_s3 <= g2_u_s2;
		c1_pos_q <= pos_q;
		if (c1_vld_q) begin
			a_q <= wk_rdata;
		end
	end

	// lerp feed from scratch reads
	assign base      = col_q ? WA_W'(MAX_U_POINTS) : WA_W'(0);
	assign lp_in_vld = c1_vld_q && (c1_pos_q != CNT_W'(0));
	assign lp_in_tag = base + WA_W'(c1_pos_q - CNT_W'(1));

	// scratch ports
	assign wk_raddr = (state_q == S_LERP) ? base + WA_W'(pos_q) : base;
	always_comb begin
		wk_we    = 1'b0;
		wk_waddr = WA_W'(g3_u_s3);
		wk_wdata = g3_val_s3;
		if (g3_vld_s3) begin
			wk_we = 1'b1;
		end else if (lp_out_vld) begin
			wk_we    = 1'b1;
			wk_waddr = lp_out_tag;
			wk_wdata = lp_out_val;
		end else if ((state_q == S_COPY2) && !col_q) begin
			wk_we    = 1'b1;
			wk_waddr = WA_W'(MAX_U_POINTS + int'(row_q));
			wk_wdata = wk_rdata;
		end
	end

	// final clamp to 32 bits
	always_comb begin
		logic signed [VAL_W-1:0]             v;
		logic [LANES-1:0][bse_pkg::COORD_W-1:0] c;
		logic                                sat;
		sat = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			v = $signed(wk_rdata[l]);
			if (v > SAT_HI) begin
				c[l] = SAT_HI[bse_pkg::COORD_W-1:0];
				sat  = 1'b1;
			end else if (v < SAT_LO) begin
				c[l] = SAT_LO[bse_pkg::COORD_W-1:0];
				sat  = 1'b1;
			end else begin
				c[l] = v[bse_pkg::COORD_W-1:0];
			end
		end
		clamp_res.result_x  = c[0];
		clamp_res.result_y  = c[1];
		clamp_res.result_z  = c[2];
		clamp_res.saturated = sat;
	end

	// point count of the set that the next de Casteljau pass runs on
	assign start_n = col_q ? nv_e_q : nu_e_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			pos_q   <= '0;
			tap_q   <= '0;
			level_q <= '0;
			col_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.req_type == bse_pkg::REQ_EVAL)) begin
						row_q   <= '0;
						pos_q   <= '0;
						tap_q   <= '0;
						col_q   <= 1'b0;
						state_q <= zero_n ? S_OUT : S_GATHER;
					end
				end
				S_GATHER: begin
					if (last_tap) begin
						tap_q <= '0;
						if (pos_q == nu_e_q - CNT_W'(1)) begin
							pos_q   <= '0;
							state_q <= S_GDRAIN;
						end else begin
							pos_q <= pos_q + CNT_W'(1);
						end
					end else begin
						tap_q <= tap_q + 2'd1;
					end
				end
				S_GDRAIN: begin
					if (!g1_vld_q && !g2_vld_s2 && !g3_vld_s3) begin
						pos_q <= '0;
						if (nu_e_q == CNT_W'(1)) begin
							state_q <= S_COPY;
						end else begin
							level_q <= nu_e_q - CNT_W'(1);
							state_q <= S_LERP;
						end
					end
				end
				S_LERP: begin
					if (pos_q == level_q) begin
						state_q <= S_LDRAIN;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				S_LDRAIN: begin
					if (!c1_vld_q && !lp_busy) begin
						pos_q <= '0;
						if (level_q == CNT_W'(1)) begin
							state_q <= S_COPY;
						end else begin
							level_q <= level_q - CNT_W'(1);
							state_q <= S_LERP;
						end
					end
				end
				S_COPY: begin
					state_q <= S_COPY2;
				end
				S_COPY2: begin
					if (col_q) begin
						state_q <= S_OUT;
					end else if (row_q == nv_e_q - CNT_W'(1)) begin
						// rows done: run the column pass
						col_q <= 1'b1;
						pos_q <= '0;
						if (nv_e_q == CNT_W'(1)) begin
							state_q <= S_COPY;
						end else begin
							level_q <= nv_e_q - CNT_W'(1);
							state_q <= S_LERP;
						end
					end else begin
						row_q   <= row_q + CNT_W'(1);
						pos_q   <= '0;
						tap_q   <= '0;
						state_q <= S_GATHER;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-evaluation payload
	always_ff @(posedge clk) begin
		if (in_acc && (in_data.req_type == bse_pkg::REQ_EVAL)) begin
			kind_q  <= kind_n;
			tu_q    <= (in_data.param_u > bse_pkg::Q_ONE) ? bse_pkg::Q_ONE : in_data.param_u;
			tv_q    <= (in_data.param_v > bse_pkg::Q_ONE) ? bse_pkg::Q_ONE : in_data.param_v;
			nu_e_q  <= u_cnt_q - CNT_W'(du_ord);
			nv_e_q  <= v_cnt_q - CNT_W'(dv_ord);
			scale_q <= scale_n;
			ntap_q  <= bse_pkg::tap_count(kind_n);
			res_q   <= '0;
		end else if ((state_q == S_COPY2) && col_q) begin
			res_q <= clamp_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!out_valid_q || !out_stall)) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bse_net_store #(
		.MAX_U_POINTS(MAX_U_POINTS),
		.MAX_V_POINTS(MAX_V_POINTS)
	) u_net (
		.clk  (clk),
		.we   (net_we),
		.waddr(net_waddr),
		.wdata(net_wdata),
		.raddr(net_raddr),
		.rdata(net_rdata)
	);

	bse_work_store #(
		.MAX_U_POINTS(MAX_U_POINTS),
		.MAX_V_POINTS(MAX_V_POINTS)
	) u_work (
		.clk  (clk),
		.we   (wk_we),
		.waddr(wk_waddr),
		.wdata(wk_wdata),
		.raddr(wk_raddr),
		.rdata(wk_rdata)
	);

	bse_lerp_pipe #(
		.TAG_W(WA_W)
	) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (lp_in_vld),
		.in_a   (a_q),
		.in_b   (wk_rdata),
		.t      (col_q ? tv_q : tu_q),
		.in_tag (lp_in_tag),
		.out_vld(lp_out_vld),
		.out_val(lp_out_val),
		.out_tag(lp_out_tag),
		.busy   (lp_busy)
	);

endmodule
